// File: hw/rtl/c2dwm_pkg.sv
// ----------------------------------------------------------------------------
// c2dwm_pkg
// Shared constants, codes and control structs of the 2-D convolution block.
// ----------------------------------------------------------------------------
package c2dwm_pkg;

   localparam int MAX_HEIGHT       = 32;
   localparam int MAX_WIDTH        = 32;
   localparam int MAX_IN_CHANNELS  = 16;
   localparam int MAX_OUT_CHANNELS = 16;
   localparam int MAX_KERNEL       = 3;

   localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH * MAX_IN_CHANNELS;
   localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS;
   localparam int BIAS_DEPTH   = MAX_OUT_CHANNELS;

   localparam int LINE_AW   = $clog2(LINE_DEPTH);
   localparam int WEIGHT_AW = $clog2(WEIGHT_DEPTH);
   localparam int BIAS_AW   = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
   localparam int SLOT_W    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   // field widths fixed by the interface
   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int CHAN_W  = 4;
   localparam int OCH_W   = 4;
   localparam int KDIM_W  = 2;
   localparam int INDEX_W = 12;
   localparam int ACC_W   = 48;

   // request kinds
   localparam logic [1:0] KIND_WEIGHT = 2'd0;
   localparam logic [1:0] KIND_BIAS   = 2'd1;
   localparam logic [1:0] KIND_SAMPLE = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_IN_HEIGHT     = 3'd0;
   localparam logic [2:0] CSR_IN_WIDTH      = 3'd1;
   localparam logic [2:0] CSR_IN_CHANNELS   = 3'd2;
   localparam logic [2:0] CSR_OUT_HEIGHT    = 3'd3;
   localparam logic [2:0] CSR_OUT_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_OUT_CHANNELS  = 3'd5;
   localparam logic [2:0] CSR_KERNEL_HEIGHT = 3'd6;
   localparam logic [2:0] CSR_KERNEL_WIDTH  = 3'd7;

   // clamped configuration, every value in [1, max]
   typedef struct packed {
      logic [5:0] in_height;
      logic [5:0] in_width;
      logic [4:0] in_channels;
      logic [5:0] out_height;
      logic [5:0] out_width;
      logic [4:0] out_channels;
      logic [1:0] kernel_height;
      logic [1:0] kernel_width;
   } cfg_type;

   typedef struct packed {
      logic                 wr_weight;
      logic                 wr_bias;
      logic                 wr_line;
      logic [LINE_AW-1:0]   line_wr_addr;
      logic                 mac_valid;
      logic                 mac_first;
      logic                 mac_last;
      logic [LINE_AW-1:0]   line_rd_addr;
      logic [WEIGHT_AW-1:0] weight_rd_addr;
      logic [BIAS_AW-1:0]   bias_rd_addr;
      logic                 load_out;
      logic [ROW_W-1:0]     out_row;
      logic [COL_W-1:0]     out_col;
      logic [OCH_W-1:0]     out_channel;
      logic                 last_of_pixel;
      logic                 last_of_frame;
   } dp_cmd_type;

   typedef struct packed {
      logic acc_done;
      logic out_free;
   } dp_status_type;

endpackage

// File: hw/rtl/c2dwm_ram.sv
// ----------------------------------------------------------------------------
// c2dwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c2dwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/c2dwm_dp.sv
// ----------------------------------------------------------------------------
// c2dwm_dp
// Datapath: line, weight and bias stores, MAC pipeline, result register.
// ----------------------------------------------------------------------------
module c2dwm_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  c2dwm_pkg::dp_cmd_type      cmd,
   output c2dwm_pkg::dp_status_type   status,
   input  logic [11:0]                req_index,
   input  logic [15:0]                req_weight,
   input  logic [31:0]                req_bias,
   input  logic [15:0]                req_sample,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   logic [15:0] line_rd;
   logic [15:0] weight_rd;
   logic [31:0] bias_rd;

   c2dwm_ram #(.WIDTH(16), .DEPTH(c2dwm_pkg::LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_line),
      .wr_addr (cmd.line_wr_addr),
      .wr_data (req_sample),
      .rd_addr (cmd.line_rd_addr),
      .rd_data (line_rd)
   );

   c2dwm_ram #(.WIDTH(16), .DEPTH(c2dwm_pkg::WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_weight),
      .wr_addr (req_index[c2dwm_pkg::WEIGHT_AW-1:0]),
      .wr_data (req_weight),
      .rd_addr (cmd.weight_rd_addr),
      .rd_data (weight_rd)
   );

   c2dwm_ram #(.WIDTH(32), .DEPTH(c2dwm_pkg::BIAS_DEPTH)) u_bias_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_bias),
      .wr_addr (req_index[c2dwm_pkg::BIAS_AW-1:0]),
      .wr_data (req_bias),
      .rd_addr (cmd.bias_rd_addr),
      .rd_data (bias_rd)
   );

   // stage tags: d1 = read data valid, d2 = product valid
   logic        valid_d1_ff, first_d1_ff, last_d1_ff;
   logic        valid_d2_ff, first_d2_ff, last_d2_ff;
   logic [31:0] prod_ff;
   logic [31:0] bias_d2_ff;
   logic [c2dwm_pkg::ACC_W-1:0] acc_ff;
   logic [c2dwm_pkg::ACC_W-1:0] acc_in;
   logic        acc_done_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_user_ff;

   always_comb begin
      acc_in = cmd.mac_valid ? acc_ff : acc_ff;
      if (first_d2_ff) begin
         acc_in = {{16{bias_d2_ff[31]}}, bias_d2_ff} + {{16{prod_ff[31]}}, prod_ff};
      end else begin
         acc_in = acc_ff + {{16{prod_ff[31]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d1_ff  <= 1'b0;
         valid_d2_ff  <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_d1_ff <= cmd.mac_valid;
         valid_d2_ff <= valid_d1_ff;
         acc_done_ff <= valid_d2_ff && last_d2_ff;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      first_d1_ff <= cmd.mac_first;
      last_d1_ff  <= cmd.mac_last;
      first_d2_ff <= first_d1_ff;
      last_d2_ff  <= last_d1_ff;
      prod_ff     <= 32'($signed(line_rd) * $signed(weight_rd));
      bias_d2_ff  <= bias_rd;
      if (valid_d2_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {2'b00, cmd.out_channel, cmd.out_col, cmd.out_row, acc_ff};
         rsp_last_ff <= cmd.last_of_frame;
         rsp_user_ff <= cmd.last_of_pixel;
      end
   end

   assign status.acc_done = acc_done_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: hw/rtl/c2dwm_ctrl.sv
// ----------------------------------------------------------------------------
// c2dwm_ctrl
// Controller: frame position counters, window detection and MAC sequencing.
// ----------------------------------------------------------------------------
module c2dwm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  c2dwm_pkg::cfg_type         cfg,
   input  logic                       cfg_wr,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [1:0]                 req_kind,
   input  logic [11:0]                req_index,
   output c2dwm_pkg::dp_cmd_type      cmd,
   input  c2dwm_pkg::dp_status_type   status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   localparam logic [c2dwm_pkg::SLOT_W-1:0] SLOT_LAST =
      c2dwm_pkg::SLOT_W'(c2dwm_pkg::MAX_KERNEL - 1);

   state_type state_ff;

   logic [c2dwm_pkg::ROW_W-1:0]  row_ff;
   logic [c2dwm_pkg::COL_W-1:0]  col_ff;
   logic [c2dwm_pkg::CHAN_W-1:0] chan_ff;
   logic [c2dwm_pkg::SLOT_W-1:0] rmod_ff;

   logic [c2dwm_pkg::ROW_W-1:0]  orow_ff;
   logic [c2dwm_pkg::COL_W-1:0]  ocol_ff;
   logic [c2dwm_pkg::SLOT_W-1:0] base_slot_ff;
   logic [c2dwm_pkg::SLOT_W-1:0] slot_ff;
   logic [c2dwm_pkg::OCH_W-1:0]  o_ff;
   logic [c2dwm_pkg::KDIM_W-1:0] r_ff;
   logic [c2dwm_pkg::KDIM_W-1:0] c_ff;
   logic [c2dwm_pkg::CHAN_W-1:0] k_ff;
   logic [c2dwm_pkg::WEIGHT_AW-1:0] w_addr_ff;

   logic                          accept;
   logic                          is_sample;
   logic                          out_of_frame;
   logic [c2dwm_pkg::ROW_W-1:0]   row_e;
   logic [c2dwm_pkg::COL_W-1:0]   col_e;
   logic [c2dwm_pkg::CHAN_W-1:0]  chan_e;
   logic [c2dwm_pkg::SLOT_W-1:0]  rmod_e;
   logic                          chan_last;
   logic                          col_last;
   logic                          row_last;
   logic [5:0]                    orow_w;
   logic [5:0]                    ocol_w;
   logic                          win_hit;
   logic [2:0]                    slot_sum;
   logic [c2dwm_pkg::SLOT_W-1:0]  base_slot;
   logic                          k_last;
   logic                          c_last;
   logic                          r_last;
   logic                          term_last;
   logic                          o_last;
   logic [c2dwm_pkg::COL_W-1:0]   rd_col;

   always_comb begin
      accept       = req_tvalid && (state_ff == ST_IDLE);
      is_sample    = accept && (req_kind == c2dwm_pkg::KIND_SAMPLE);
      out_of_frame = ({1'b0, row_ff} >= cfg.in_height) || ({1'b0, col_ff} >= cfg.in_width)
                     || ({1'b0, chan_ff} >= cfg.in_channels);
      row_e  = out_of_frame ? '0 : row_ff;
      col_e  = out_of_frame ? '0 : col_ff;
      chan_e = out_of_frame ? '0 : chan_ff;
      rmod_e = out_of_frame ? '0 : rmod_ff;

      chan_last = ({1'b0, chan_e} + 5'd1) == cfg.in_channels;
      col_last  = ({1'b0, col_e} + 6'd1) >= cfg.in_width;
      row_last  = ({1'b0, row_e} + 6'd1) >= cfg.in_height;

      orow_w  = {1'b0, row_e} + 6'd1 - {4'b0, cfg.kernel_height};
      ocol_w  = {1'b0, col_e} + 6'd1 - {4'b0, cfg.kernel_width};
      win_hit = chan_last
                && (({1'b0, row_e} + 6'd1) >= {4'b0, cfg.kernel_height})
                && (({1'b0, col_e} + 6'd1) >= {4'b0, cfg.kernel_width})
                && (orow_w < cfg.out_height) && (ocol_w < cfg.out_width);

      // line slot of the window's top row
      slot_sum  = 3'(rmod_e) + 3'(c2dwm_pkg::MAX_KERNEL + 1) - {1'b0, cfg.kernel_height};
      base_slot = (slot_sum >= 3'(c2dwm_pkg::MAX_KERNEL))
                  ? c2dwm_pkg::SLOT_W'(slot_sum - 3'(c2dwm_pkg::MAX_KERNEL))
                  : c2dwm_pkg::SLOT_W'(slot_sum);

      k_last    = ({1'b0, k_ff} + 5'd1) == cfg.in_channels;
      c_last    = (c_ff + 2'd1) == cfg.kernel_width;
      r_last    = (r_ff + 2'd1) == cfg.kernel_height;
      term_last = k_last && c_last && r_last;
      o_last    = ({1'b0, o_ff} + 5'd1) == cfg.out_channels;
      rd_col    = ocol_ff + c2dwm_pkg::COL_W'(c_ff);

      cmd.wr_weight = accept && (req_kind == c2dwm_pkg::KIND_WEIGHT)
                      && (32'(req_index) < 32'(c2dwm_pkg::WEIGHT_DEPTH));
      cmd.wr_bias   = accept && (req_kind == c2dwm_pkg::KIND_BIAS)
                      && (32'(req_index) < 32'(c2dwm_pkg::BIAS_DEPTH));
      cmd.wr_line   = is_sample;
      cmd.line_wr_addr = c2dwm_pkg::LINE_AW'(
         (32'(rmod_e) * c2dwm_pkg::MAX_WIDTH + 32'(col_e)) * c2dwm_pkg::MAX_IN_CHANNELS
         + 32'(chan_e));
      cmd.mac_valid = (state_ff == ST_MAC);
      cmd.mac_first = (r_ff == '0) && (c_ff == '0) && (k_ff == '0);
      cmd.mac_last  = term_last;
      cmd.line_rd_addr = c2dwm_pkg::LINE_AW'(
         (32'(slot_ff) * c2dwm_pkg::MAX_WIDTH + 32'(rd_col)) * c2dwm_pkg::MAX_IN_CHANNELS
         + 32'(k_ff));
      cmd.weight_rd_addr = w_addr_ff;
      cmd.bias_rd_addr   = c2dwm_pkg::BIAS_AW'(o_ff);
      cmd.load_out       = (state_ff == ST_EMIT) && status.out_free;
      cmd.out_row        = orow_ff;
      cmd.out_col        = ocol_ff;
      cmd.out_channel    = o_ff;
      cmd.last_of_pixel  = o_last;
      cmd.last_of_frame  = o_last && (({1'b0, orow_ff} + 6'd1) == cfg.out_height)
                           && (({1'b0, ocol_ff} + 6'd1) == cfg.out_width);

      req_tready = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         chan_ff  <= '0;
         rmod_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (is_sample) begin
                  if (chan_last) begin
                     chan_ff <= '0;
                     if (col_last) begin
                        col_ff <= '0;
                        if (row_last) begin
                           row_ff  <= '0;
                           rmod_ff <= '0;
                        end else begin
                           row_ff  <= row_e + 5'd1;
                           rmod_ff <= (rmod_e == SLOT_LAST) ? '0 : rmod_e + 1'b1;
                        end
                     end else begin
                        col_ff  <= col_e + 5'd1;
                        row_ff  <= row_e;
                        rmod_ff <= rmod_e;
                     end
                  end else begin
                     chan_ff <= chan_e + 4'd1;
                     col_ff  <= col_e;
                     row_ff  <= row_e;
                     rmod_ff <= rmod_e;
                  end
                  if (win_hit) begin
                     orow_ff      <= orow_w[c2dwm_pkg::ROW_W-1:0];
                     ocol_ff      <= ocol_w[c2dwm_pkg::COL_W-1:0];
                     base_slot_ff <= base_slot;
                     slot_ff      <= base_slot;
                     o_ff         <= '0;
                     r_ff         <= '0;
                     c_ff         <= '0;
                     k_ff         <= '0;
                     w_addr_ff    <= '0;
                     state_ff     <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               w_addr_ff <= w_addr_ff + 1'b1;
               if (term_last) begin
                  state_ff <= ST_DRAIN;
               end else if (k_last) begin
                  k_ff <= '0;
                  if (c_last) begin
                     c_ff    <= '0;
                     r_ff    <= r_ff + 2'd1;
                     slot_ff <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
                  end else begin
                     c_ff <= c_ff + 2'd1;
                  end
               end else begin
                  k_ff <= k_ff + 4'd1;
               end
            end
            ST_DRAIN: begin
               if (status.acc_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  if (o_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     o_ff     <= o_ff + 4'd1;
                     r_ff     <= '0;
                     c_ff     <= '0;
                     k_ff     <= '0;
                     slot_ff  <= base_slot_ff;
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cfg_wr) begin
            row_ff  <= '0;
            col_ff  <= '0;
            chan_ff <= '0;
            rmod_ff <= '0;
         end
      end
   end

   // accumulator finishes only while the controller waits for it
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.acc_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator done outside drain");

   // a result is never loaded over one that is still waiting
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result register overwritten");

   // a register write restarts the frame
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (row_ff == '0) && (col_ff == '0) && (chan_ff == '0))
      else $error("frame position not cleared by register write");

endmodule

// File: hw/rtl/conv2d_window_mac.sv
// ----------------------------------------------------------------------------
// conv2d_window_mac
// Valid stride-1 2-D convolution over an HWC request stream, one MAC unit.
// ----------------------------------------------------------------------------
// Weight/bias loads and samples that close no window leave the block idle.
// A sample that closes a window produces out_channels results; each sums
// kernel_height*kernel_width*in_channels products (up to 144) on the single
// multiplier, then drains the pipeline and loads the result register. No new
// request is taken before the last result is loaded, which result stalls delay.
// Reset: registers to defaults, frame position to zero; stores stay undefined.
module conv2d_window_mac (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // table_index[11:0], weight_value[27:12],
                                    // bias_value[59:28], sample_value[75:60]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // conv_value[47:0], out_row[52:48],
                                    // out_col[57:53], out_channel[61:58]
   output logic        rsp_tlast,   // last_of_frame
   output logic        rsp_tuser,   // last_of_pixel
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [5:0] in_height_ff;
   logic [5:0] in_width_ff;
   logic [4:0] in_channels_ff;
   logic [5:0] out_height_ff;
   logic [5:0] out_width_ff;
   logic [4:0] out_channels_ff;
   logic [1:0] kernel_height_ff;
   logic [1:0] kernel_width_ff;

   logic                      cfg_wr;
   logic [2:0]                csr_index;
   c2dwm_pkg::cfg_type        cfg;
   c2dwm_pkg::dp_cmd_type     cmd;
   c2dwm_pkg::dp_status_type  status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_height_ff     <= 6'd28;
         in_width_ff      <= 6'd28;
         in_channels_ff   <= 5'd1;
         out_height_ff    <= 6'd26;
         out_width_ff     <= 6'd26;
         out_channels_ff  <= 5'd8;
         kernel_height_ff <= 2'd3;
         kernel_width_ff  <= 2'd3;
      end else if (cfg_wr) begin
         unique case (csr_index)
            c2dwm_pkg::CSR_IN_HEIGHT:     in_height_ff     <= csr_pwdata[5:0];
            c2dwm_pkg::CSR_IN_WIDTH:      in_width_ff      <= csr_pwdata[5:0];
            c2dwm_pkg::CSR_IN_CHANNELS:   in_channels_ff   <= csr_pwdata[4:0];
            c2dwm_pkg::CSR_OUT_HEIGHT:    out_height_ff    <= csr_pwdata[5:0];
            c2dwm_pkg::CSR_OUT_WIDTH:     out_width_ff     <= csr_pwdata[5:0];
            c2dwm_pkg::CSR_OUT_CHANNELS:  out_channels_ff  <= csr_pwdata[4:0];
            c2dwm_pkg::CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_pwdata[1:0];
            c2dwm_pkg::CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         c2dwm_pkg::CSR_IN_HEIGHT:     csr_prdata = {26'b0, in_height_ff};
         c2dwm_pkg::CSR_IN_WIDTH:      csr_prdata = {26'b0, in_width_ff};
         c2dwm_pkg::CSR_IN_CHANNELS:   csr_prdata = {27'b0, in_channels_ff};
         c2dwm_pkg::CSR_OUT_HEIGHT:    csr_prdata = {26'b0, out_height_ff};
         c2dwm_pkg::CSR_OUT_WIDTH:     csr_prdata = {26'b0, out_width_ff};
         c2dwm_pkg::CSR_OUT_CHANNELS:  csr_prdata = {27'b0, out_channels_ff};
         c2dwm_pkg::CSR_KERNEL_HEIGHT: csr_prdata = {30'b0, kernel_height_ff};
         c2dwm_pkg::CSR_KERNEL_WIDTH:  csr_prdata = {30'b0, kernel_width_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // registers are used clamped to [1, max]; zero means one
   always_comb begin
      cfg.in_height = (in_height_ff == '0) ? 6'd1
         : (in_height_ff > 6'(c2dwm_pkg::MAX_HEIGHT)) ? 6'(c2dwm_pkg::MAX_HEIGHT)
         : in_height_ff;
      cfg.in_width = (in_width_ff == '0) ? 6'd1
         : (in_width_ff > 6'(c2dwm_pkg::MAX_WIDTH)) ? 6'(c2dwm_pkg::MAX_WIDTH)
         : in_width_ff;
      cfg.in_channels = (in_channels_ff == '0) ? 5'd1
         : (in_channels_ff > 5'(c2dwm_pkg::MAX_IN_CHANNELS)) ? 5'(c2dwm_pkg::MAX_IN_CHANNELS)
         : in_channels_ff;
      cfg.out_height = (out_height_ff == '0) ? 6'd1
         : (out_height_ff > 6'(c2dwm_pkg::MAX_HEIGHT)) ? 6'(c2dwm_pkg::MAX_HEIGHT)
         : out_height_ff;
      cfg.out_width = (out_width_ff == '0) ? 6'd1
         : (out_width_ff > 6'(c2dwm_pkg::MAX_WIDTH)) ? 6'(c2dwm_pkg::MAX_WIDTH)
         : out_width_ff;
      cfg.out_channels = (out_channels_ff == '0) ? 5'd1
         : (out_channels_ff > 5'(c2dwm_pkg::MAX_OUT_CHANNELS))
           ? 5'(c2dwm_pkg::MAX_OUT_CHANNELS) : out_channels_ff;
      cfg.kernel_height = (kernel_height_ff == '0) ? 2'd1
         : (kernel_height_ff > 2'(c2dwm_pkg::MAX_KERNEL)) ? 2'(c2dwm_pkg::MAX_KERNEL)
         : kernel_height_ff;
      cfg.kernel_width = (kernel_width_ff == '0) ? 2'd1
         : (kernel_width_ff > 2'(c2dwm_pkg::MAX_KERNEL)) ? 2'(c2dwm_pkg::MAX_KERNEL)
         : kernel_width_ff;
   end

   c2dwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_wr     (cfg_wr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[11:0]),
      .cmd        (cmd),
      .status     (status)
   );

   c2dwm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_index  (req_tdata[11:0]),
      .req_weight (req_tdata[27:12]),
      .req_bias   (req_tdata[59:28]),
      .req_sample (req_tdata[75:60]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for conv2d_window_mac. Weight, bias and sample requests
// go in on the request stream. A predictor inside the bench keeps its own
// copy of the stores and of the frame position, and queues the expected
// window sums. A checker compares every result against that queue.
// ----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;   // cycles with no handshake at all
   localparam int DRAIN_WAIT  = 100;     // covers one no-result request plus slack
   localparam int ITEM_TARGET = 380;
   localparam logic [1:0] KIND_DROPPED = 2'd3;   // unused kind, ignored by the block

   typedef struct {
      logic [47:0] conv_value;
      logic [4:0]  out_row;
      logic [4:0]  out_col;
      logic [3:0]  out_channel;
      logic        last_of_pixel;
      logic        last_of_frame;
   } conv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // table_index, weight_value, bias_value, sample_value
   logic [1:0]  req_tuser = c2dwm_pkg::KIND_WEIGHT;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;   // conv_value, out_row, out_col, out_channel
   logic        rsp_tlast;   // last_of_frame
   logic        rsp_tuser;   // last_of_pixel
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   conv2d_window_mac dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   logic signed [15:0] line_mem [c2dwm_pkg::LINE_DEPTH];
   logic signed [15:0] weight_mem [c2dwm_pkg::WEIGHT_DEPTH];
   logic signed [31:0] bias_mem [c2dwm_pkg::BIAS_DEPTH];
   bit                 weight_loaded [c2dwm_pkg::WEIGHT_DEPTH];
   bit                 bias_loaded [c2dwm_pkg::BIAS_DEPTH];
   int                 cfg_raw [8];
   int                 pos_row, pos_col, pos_chan;

   conv_result_type expected_sums [$];
   int           error_count = 0;
   int           item_count = 0;
   bit           no_gaps = 0;     // burst stretches: no idling on either side
   int           quiet_cycles = 0;

   function automatic int clamp_cfg(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int cfg_val(logic [2:0] idx);
      int hi;
      case (idx)
         c2dwm_pkg::CSR_IN_HEIGHT, c2dwm_pkg::CSR_OUT_HEIGHT: hi = c2dwm_pkg::MAX_HEIGHT;
         c2dwm_pkg::CSR_IN_WIDTH, c2dwm_pkg::CSR_OUT_WIDTH:   hi = c2dwm_pkg::MAX_WIDTH;
         c2dwm_pkg::CSR_IN_CHANNELS:                          hi = c2dwm_pkg::MAX_IN_CHANNELS;
         c2dwm_pkg::CSR_OUT_CHANNELS:                         hi = c2dwm_pkg::MAX_OUT_CHANNELS;
         default:                                             hi = c2dwm_pkg::MAX_KERNEL;
      endcase
      return clamp_cfg(cfg_raw[idx], hi);
   endfunction

   // Applies one accepted request to the shadow state and queues its sums.
   task automatic predict_request(logic [1:0] kind, logic [11:0] idx,
                                  logic signed [15:0] wval, logic signed [31:0] bval,
                                  logic signed [15:0] sval);
      int ih, iw, ic, oh, ow, oc, kh, kw;
      int row, col, chan, orow, ocol, lrow, lbase, wbase;
      logic signed [47:0] acc;
      conv_result_type res;
      ih = cfg_val(c2dwm_pkg::CSR_IN_HEIGHT);
      iw = cfg_val(c2dwm_pkg::CSR_IN_WIDTH);
      ic = cfg_val(c2dwm_pkg::CSR_IN_CHANNELS);
      oh = cfg_val(c2dwm_pkg::CSR_OUT_HEIGHT);
      ow = cfg_val(c2dwm_pkg::CSR_OUT_WIDTH);
      oc = cfg_val(c2dwm_pkg::CSR_OUT_CHANNELS);
      kh = cfg_val(c2dwm_pkg::CSR_KERNEL_HEIGHT);
      kw = cfg_val(c2dwm_pkg::CSR_KERNEL_WIDTH);
      case (kind)
         c2dwm_pkg::KIND_WEIGHT: begin
            if (idx < c2dwm_pkg::WEIGHT_DEPTH) begin
               weight_mem[idx] = wval;
               weight_loaded[idx] = 1;
            end
         end
         c2dwm_pkg::KIND_BIAS: begin
            if (idx < c2dwm_pkg::BIAS_DEPTH) begin
               bias_mem[idx] = bval;
               bias_loaded[idx] = 1;
            end
         end
         c2dwm_pkg::KIND_SAMPLE: begin
            row = pos_row; col = pos_col; chan = pos_chan;
            if (row >= ih || col >= iw || chan >= ic) begin
               row = 0; col = 0; chan = 0;
            end
            line_mem[((row % c2dwm_pkg::MAX_KERNEL) * c2dwm_pkg::MAX_WIDTH + col)
                     * c2dwm_pkg::MAX_IN_CHANNELS + chan] = sval;
            // last channel of a pixel closes a window once enough rows/cols are in
            if (chan == ic - 1 && row + 1 >= kh && col + 1 >= kw) begin
               orow = row + 1 - kh;
               ocol = col + 1 - kw;
               if (orow < oh && ocol < ow) begin
                  for (int o = 0; o < oc; o++) begin
                     acc = bias_mem[o];
                     for (int r = 0; r < kh; r++) begin
                        lrow = (orow + r) % c2dwm_pkg::MAX_KERNEL;
                        for (int c = 0; c < kw; c++) begin
                           lbase = (lrow * c2dwm_pkg::MAX_WIDTH + ocol + c)
                                   * c2dwm_pkg::MAX_IN_CHANNELS;
                           wbase = o * kh * kw * ic + (r * kw + c) * ic;
                           for (int k = 0; k < ic; k++)
                              acc += line_mem[lbase + k] * weight_mem[wbase + k];
                        end
                     end
                     res.conv_value    = acc;
                     res.out_row       = orow[4:0];
                     res.out_col       = ocol[4:0];
                     res.out_channel   = o[3:0];
                     res.last_of_pixel = (o == oc - 1);
                     res.last_of_frame = (o == oc - 1) && orow == oh - 1 && ocol == ow - 1;
                     expected_sums.push_back(res);
                  end
               end
            end
            chan++;
            if (chan >= ic) begin
               chan = 0;
               col++;
               if (col >= iw) begin
                  col = 0;
                  row++;
                  if (row >= ih) row = 0;
               end
            end
            pos_row = row; pos_col = col; pos_chan = chan;
         end
         default: ;   // kind three is dropped by the block
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic int gap_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Sends one request and waits for its handshake. Valid is left high on
   // return; whoever lets time pass next lowers it first.
   task automatic send_request(logic [1:0] kind, logic [11:0] idx,
                               logic [15:0] wval, logic [31:0] bval, logic [15:0] sval);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, sval, bval, wval, idx};
      do @(posedge clock); while (!req_tready);
      predict_request(kind, idx, wval, bval, sval);
      if (kind != KIND_DROPPED) item_count++;
   endtask

   task automatic send_weight(int idx, logic [15:0] wval);
      send_request(c2dwm_pkg::KIND_WEIGHT, idx[11:0], wval, $urandom, 16'($urandom));
   endtask

   task automatic send_bias(int idx, logic [31:0] bval);
      send_request(c2dwm_pkg::KIND_BIAS, idx[11:0], 16'($urandom), bval, 16'($urandom));
   endtask

   task automatic send_sample(logic [15:0] sval);
      send_request(c2dwm_pkg::KIND_SAMPLE, 12'($urandom), 16'($urandom), $urandom, sval);
   endtask

   // Lets every queued sum drain, then the tail of any no-result request.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int val);
      int widths [8] = '{6, 6, 5, 6, 6, 5, 2, 2};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cfg_raw[idx] = val & ((1 << widths[idx]) - 1);
      pos_row = 0; pos_col = 0; pos_chan = 0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_shape(int ih, int iw, int ic, int oh, int ow, int oc, int kh, int kw);
      csr_write(c2dwm_pkg::CSR_IN_HEIGHT, ih);
      csr_write(c2dwm_pkg::CSR_IN_WIDTH, iw);
      csr_write(c2dwm_pkg::CSR_IN_CHANNELS, ic);
      csr_write(c2dwm_pkg::CSR_OUT_HEIGHT, oh);
      csr_write(c2dwm_pkg::CSR_OUT_WIDTH, ow);
      csr_write(c2dwm_pkg::CSR_OUT_CHANNELS, oc);
      csr_write(c2dwm_pkg::CSR_KERNEL_HEIGHT, kh);
      csr_write(c2dwm_pkg::CSR_KERNEL_WIDTH, kw);
   endtask

   // Fills every weight and bias the current shape will read and that was
   // never written, so the block never sums an undefined entry.
   task automatic load_missing();
      int n;
      n = cfg_val(c2dwm_pkg::CSR_OUT_CHANNELS) * cfg_val(c2dwm_pkg::CSR_KERNEL_HEIGHT)
          * cfg_val(c2dwm_pkg::CSR_KERNEL_WIDTH) * cfg_val(c2dwm_pkg::CSR_IN_CHANNELS);
      for (int i = 0; i < n; i++)
         if (!weight_loaded[i]) send_weight(i, 16'($urandom));
      for (int o = 0; o < cfg_val(c2dwm_pkg::CSR_OUT_CHANNELS); o++)
         if (!bias_loaded[o]) send_bias(o, $urandom);
   endtask

   // Full-scale weights, samples and biases, dropped kinds and loads past the store.
   task automatic test_extreme_values();
      set_shape(1, 1, 1, 1, 1, 2, 1, 1);
      send_weight(0, 16'h8000);
      send_weight(1, 16'h7fff);
      send_bias(0, 32'h8000_0000);
      send_bias(1, 32'h7fff_ffff);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h0000);
      send_request(KIND_DROPPED, 12'hfff, 16'hffff, 32'hffff_ffff, 16'hffff);
      send_weight(c2dwm_pkg::WEIGHT_DEPTH, 16'h1234);
      send_weight(4095, 16'h4321);
      send_bias(c2dwm_pkg::BIAS_DEPTH, 32'h1234_5678);
      send_bias(4095, 32'h0bad_f00d);
      send_sample(16'h8000);
      wait_idle();
   endtask

   // Widest frame with the widest kernel and every output channel.
   task automatic test_wide_frame();
      set_shape(1, 32, 1, 1, 30, 16, 1, 3);
      load_missing();
      for (int i = 0; i < 32; i++) send_sample(16'($urandom));
      wait_idle();
   endtask

   // Out-of-range register values: zero and all ones clamp to their limits.
   task automatic test_clamped_registers();
      set_shape(0, 63, 31, 0, 63, 0, 0, 0);
      load_missing();
      for (int i = 0; i < 2 * c2dwm_pkg::MAX_IN_CHANNELS; i++) send_sample(16'($urandom));
      wait_idle();
   endtask

   // Small random shapes, whole and cut-short frames, noise mixed in.
   task automatic test_random_frames();
      int ih, iw, ic, kh, kw, nsamp;
      while (item_count < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         ih = $urandom_range(1, 5);
         iw = $urandom_range(1, 5);
         ic = $urandom_range(1, 3);
         kh = $urandom_range(1, 3);
         kw = $urandom_range(1, 3);
         set_shape(ih, iw, ic, $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(1, 4), kh, kw);
         load_missing();
         nsamp = ih * iw * ic * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) nsamp = $urandom_range(1, nsamp);
         for (int i = 0; i < nsamp; i++) begin
            case ($urandom_range(0, 19))
               0: send_request(KIND_DROPPED, 12'($urandom), 16'($urandom), $urandom,
                               16'($urandom));
               1: send_weight($urandom_range(c2dwm_pkg::WEIGHT_DEPTH, 4095), 16'($urandom));
               2: send_bias($urandom_range(c2dwm_pkg::BIAS_DEPTH, 4095), $urandom);
               3: send_bias($urandom_range(0, cfg_val(c2dwm_pkg::CSR_OUT_CHANNELS) - 1),
                            $urandom);
               4: send_weight($urandom_range(0, cfg_val(c2dwm_pkg::CSR_IN_CHANNELS) - 1),
                              16'($urandom));
               default: ;
            endcase
            send_sample(16'($urandom));
         end
         wait_idle();   // sender holds off until every sum is back
      end
      no_gaps = 0;
   endtask

   // ---------------------------------------------------------------- checker
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sums.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, '0);
         end else begin
            want = expected_sums.pop_front();
            if (rsp_tdata[47:0] !== want.conv_value)
               report_mismatch("conv_value", rsp_tdata[47:0], want.conv_value);
            if (rsp_tdata[52:48] !== want.out_row)
               report_mismatch("out_row", rsp_tdata[52:48], want.out_row);
            if (rsp_tdata[57:53] !== want.out_col)
               report_mismatch("out_col", rsp_tdata[57:53], want.out_col);
            if (rsp_tdata[61:58] !== want.out_channel)
               report_mismatch("out_channel", rsp_tdata[61:58], want.out_channel);
            if (rsp_tuser !== want.last_of_pixel)
               report_mismatch("last_of_pixel", rsp_tuser, want.last_of_pixel);
            if (rsp_tlast !== want.last_of_frame)
               report_mismatch("last_of_frame", rsp_tlast, want.last_of_frame);
         end
      end
   end

   // Result side back-pressure: random stalls, mostly short.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) < 3) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      cfg_raw = '{28, 28, 1, 26, 26, 8, 3, 3};
      pos_row = 0; pos_col = 0; pos_chan = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_values();
      test_wide_frame();
      test_clamped_registers();
      test_random_frames();
      wait_idle();
      if (error_count == 0 && expected_sums.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: conv2d_window_mac.f
hw/rtl/c2dwm_pkg.sv
hw/rtl/c2dwm_ram.sv
hw/rtl/c2dwm_dp.sv
hw/rtl/c2dwm_ctrl.sv
hw/rtl/conv2d_window_mac.sv
bench/testbench.sv
